### design/ceeu_pkg.sv
package ceeu_pkg;

    // Operation selected by an input item.
    typedef enum logic [1:0] {
        FUNC_RAISE  = 2'd0,
        FUNC_IRQ    = 2'd1,
        FUNC_POLL   = 2'd2,
        FUNC_STATUS = 2'd3
    } t_func;

    // Exception kinds that need special handling.
    localparam logic [3:0] EXC_SYSCALL = 4'd10;
    localparam logic [3:0] EXC_FLOAT   = 4'd13;
    localparam logic [3:0] EXC_TICK    = 4'd14;
    localparam logic [3:0] EXC_EXT     = 4'd15;

    // Status register bit positions.
    localparam int SR_SM  = 0;
    localparam int SR_TEE = 1;
    localparam int SR_IEE = 2;
    localparam int SR_DME = 5;
    localparam int SR_IME = 6;
    localparam int SR_DSX = 13;
    localparam int SR_EPH = 14;
    localparam int SR_FO  = 15;

    localparam logic [15:0] STATUS_RESET = 16'h8001;
    localparam logic [31:0] VEC_HIGH     = 32'hf000_0000;

    // Configuration register indexes.
    localparam logic [0:0] REG_LINE_ENABLE = 1'b0;
    localparam logic [31:0] LINE_ENABLE_RESET = 32'd3;

    // Input item, fields as carried in the stream data.
    typedef struct packed {
        logic [15:0] status_value;
        logic        irq_level;
        logic [4:0]  irq_line;
        logic        in_delay;
        logic        in_jump;
        logic [31:0] jump_target;
        logic [31:0] prev_pc;
        logic [31:0] next_pc;
        logic [31:0] fault_addr;
        logic [3:0]  exc_type;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic        wake;
        logic [15:0] status_now;
        logic [15:0] saved_status;
        logic [31:0] saved_addr;
        logic [31:0] saved_pc;
        logic        redirect_now;
        logic [31:0] vector_pc;
        logic        taken;
    } t_out_item;

    // Handler offsets in vector table order.
    function automatic logic [31:0] vec_addr(input logic [3:0] kind);
        logic [31:0] v;
        unique case (kind)
            4'd0:    v = 32'h0000_0100;
            4'd1:    v = 32'h0000_0600;
            4'd2:    v = 32'h0000_0a00;
            4'd3:    v = 32'h0000_0400;
            4'd4:    v = 32'h0000_0200;
            4'd5:    v = 32'h0000_0600;
            4'd6:    v = 32'h0000_0900;
            4'd7:    v = 32'h0000_0300;
            4'd8:    v = 32'h0000_0200;
            4'd9:    v = 32'h0000_0700;
            4'd10:   v = 32'h0000_0c00;
            4'd11:   v = 32'h0000_0e00;
            4'd12:   v = 32'h0000_0b00;
            4'd13:   v = 32'h0000_0d00;
            4'd14:   v = 32'h0000_0500;
            default: v = 32'h0000_0800;
        endcase
        return v;
    endfunction

endpackage

### design/cpu_exception_entry_unit.sv
// Exception entry unit: takes one item per clock cycle and returns one result
// per item through an input register followed by the result register; a
// stalled result holds the unit back only once both stages are full. The
// status register, saved PC, saved address, saved status and pending interrupt
// lines are updated when an item moves from the input register to the result
// register, so each result sees every earlier item.
// The interrupt mask is written through the APB port at address 0.
module cpu_exception_entry_unit
    import ceeu_pkg::*;
#(
    parameter int NUM_IRQ_LINES = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream.
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata from bit 0: exc_type[3:0], fault_addr[35:4], next_pc[67:36],
    // prev_pc[99:68], jump_target[131:100], in_jump[132], in_delay[133],
    // irq_line[138:134], irq_level[139], status_value[155:140], zero pad.
    input  logic [159:0] i_s_tdata,
    // tuser: func[1:0].
    input  logic [1:0]   i_s_tuser,
    // Result stream.
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata from bit 0: taken[0], vector_pc[32:1], redirect_now[33],
    // saved_pc[65:34], saved_addr[97:66], saved_status[113:98],
    // status_now[129:114], wake[130], zero pad.
    output logic [135:0] o_m_tdata,
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int IN_W = $bits(t_in_item);

    // Pipeline registers.
    logic                     r_in_vld;
    t_in_item                 r_in;
    t_func                    r_func;
    logic                     r_out_vld;
    t_out_item                r_out;

    // Architectural state.
    logic [31:0]              r_line_enable;
    logic [15:0]              r_status;
    logic [31:0]              r_exc_pc;
    logic [31:0]              r_exc_addr;
    logic [15:0]              r_exc_status;
    logic [NUM_IRQ_LINES-1:0] r_irq_pending;

    logic                     adv;
    logic                     move;

    // Next-state values.
    logic [15:0]              n_status;
    logic [31:0]              n_exc_pc;
    logic [31:0]              n_exc_addr;
    logic [15:0]              n_exc_status;
    logic [NUM_IRQ_LINES-1:0] n_irq_pending;
    t_out_item                n_out;

    // Datapath temporaries.
    logic [3:0]               kind;
    logic                     want;
    logic                     take;
    logic                     is_async;
    logic [31:0]              epc;
    logic [15:0]              entry_status;
    logic [31:0]              vec;
    logic [NUM_IRQ_LINES-1:0] line_bit;

    // Handshake: the result register frees when empty or taken.
    assign adv        = !r_out_vld || i_m_tready;
    assign move       = r_in_vld && adv;
    assign o_s_tready = !r_in_vld || adv;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {5'd0, r_out};

    // APB: always ready, one register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LINE_ENABLE) ? r_line_enable : 32'd0;

    // Exception entry and item decode.
    always_comb begin
        kind     = (r_func == FUNC_RAISE) ? r_in.exc_type : EXC_EXT;
        is_async = (kind == EXC_TICK) || (kind == EXC_EXT);
        want     = (r_func == FUNC_RAISE) ||
                   ((r_func == FUNC_POLL) &&
                    (|(r_irq_pending & r_line_enable[NUM_IRQ_LINES-1:0])));
        take     = want &&
                   !((kind == EXC_EXT) && !r_status[SR_IEE]) &&
                   !((kind == EXC_TICK) && !r_status[SR_TEE]);

        // Saved PC depends on the exception class and the jump position.
        if ((kind == EXC_SYSCALL) || (kind == EXC_FLOAT)) begin
            epc = r_in.in_jump ? r_in.jump_target : r_in.next_pc + 32'd4;
        end else if (is_async) begin
            epc = r_in.in_jump ? r_in.prev_pc : r_in.next_pc;
        end else begin
            epc = r_in.in_delay ? r_in.prev_pc : r_in.next_pc;
        end

        entry_status         = r_status;
        entry_status[SR_SM]  = 1'b1;
        entry_status[SR_DSX] = r_in.in_delay;
        entry_status[SR_IEE] = 1'b0;
        entry_status[SR_TEE] = 1'b0;
        entry_status[SR_IME] = 1'b0;
        entry_status[SR_DME] = 1'b0;

        vec = vec_addr(kind) | (r_status[SR_EPH] ? VEC_HIGH : 32'd0);

        // Lines at or above the line count fall off the truncation.
        line_bit = NUM_IRQ_LINES'(32'd1 << r_in.irq_line);

        n_status      = r_status;
        n_exc_pc      = r_exc_pc;
        n_exc_addr    = r_exc_addr;
        n_exc_status  = r_exc_status;
        n_irq_pending = r_irq_pending;

        if (take) begin
            n_exc_pc     = epc;
            n_exc_addr   = (r_func == FUNC_RAISE) ? r_in.fault_addr : 32'd0;
            n_exc_status = r_status;
            n_status     = entry_status;
        end

        if (r_func == FUNC_IRQ) begin
            if (r_in.irq_level) begin
                n_irq_pending = r_irq_pending | line_bit;
            end else begin
                n_irq_pending = r_irq_pending & ~line_bit;
            end
        end

        if (r_func == FUNC_STATUS) begin
            n_status         = r_in.status_value;
            n_status[SR_FO]  = 1'b1;
        end

        n_out.taken        = take;
        n_out.vector_pc    = take ? vec : 32'd0;
        n_out.redirect_now = take && is_async;
        n_out.saved_pc     = n_exc_pc;
        n_out.saved_addr   = n_exc_addr;
        n_out.saved_status = n_exc_status;
        n_out.status_now   = n_status;
        n_out.wake         = take;
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_line_enable <= LINE_ENABLE_RESET;
            r_status      <= STATUS_RESET;
            r_exc_pc      <= 32'd0;
            r_exc_addr    <= 32'd0;
            r_exc_status  <= 16'd0;
            r_irq_pending <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_vld <= i_s_tvalid;
            end
            if (adv) begin
                r_out_vld <= r_in_vld;
            end
            if (move) begin
                r_status      <= n_status;
                r_exc_pc      <= n_exc_pc;
                r_exc_addr    <= n_exc_addr;
                r_exc_status  <= n_exc_status;
                r_irq_pending <= n_irq_pending;
            end
            if (psel && penable && pwrite && pready &&
                (paddr[2] == REG_LINE_ENABLE)) begin
                r_line_enable <= pwdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in   <= t_in_item'(i_s_tdata[IN_W-1:0]);
            r_func <= t_func'(i_s_tuser);
        end
        if (move) begin
            r_out <= n_out;
        end
    end

endmodule
